FILE: rtl/lossless_pixel_predictor_residual_macros.svh
// assertion macros for the pixel predictor block
`ifndef LOSSLESS_PIXEL_PREDICTOR_RESIDUAL_MACROS_SVH
`define LOSSLESS_PIXEL_PREDICTOR_RESIDUAL_MACROS_SVH
`ifndef SYNTHESIS
`define LPPR_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lppr assertion failed");
`define LPPR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lppr assertion failed");
`else
`define LPPR_ASSERT_SAME(label, ante, cons)
`define LPPR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/lppr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lppr_pkg;
	localparam int CHAN_W = 8;
	localparam int PIX_W = 3 * CHAN_W;
	localparam int MAX_WIDTH = 1024;
	localparam int ADDR_W = $clog2(MAX_WIDTH);
	localparam int MODE_W = 4;
	localparam int WIDTH_W = 11;
	localparam int HEIGHT_W = 16;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int WEFF_W = (WIDTH_W > ADDR_W) ? WIDTH_W : ADDR_W + 1;

	localparam logic [MODE_W-1:0] PM_PIXEL = 4'd0;
	localparam logic [MODE_W-1:0] PM_W = 4'd1;
	localparam logic [MODE_W-1:0] PM_N = 4'd2;
	localparam logic [MODE_W-1:0] PM_NW = 4'd3;
	localparam logic [MODE_W-1:0] PM_PLANE = 4'd4;
	localparam logic [MODE_W-1:0] PM_N_HALF = 4'd5;
	localparam logic [MODE_W-1:0] PM_W_HALF = 4'd6;
	localparam logic [MODE_W-1:0] PM_AVG = 4'd7;
	localparam logic [MODE_W-1:0] PM_MED = 4'd8;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

	localparam logic [MODE_W-1:0] MODE_RST = PM_MED;
	localparam logic [WIDTH_W-1:0] WIDTH_RST = 11'd1024;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd1024;

	typedef logic [CHAN_W-1:0] chan_t;

	function automatic chan_t predict(input logic [MODE_W-1:0] mode, input chan_t cur,
		input chan_t n, input chan_t w, input chan_t nw, input logic top,
		input logic leftcol);
		logic [CHAN_W:0] d;
		logic [CHAN_W:0] t;
		logic [CHAN_W:0] s;
		chan_t h;
		chan_t p;
		chan_t plane;
		d = {1'b0, w} - {1'b0, nw};
		t = d + {{CHAN_W{1'b0}}, d[CHAN_W]};
		h = t[CHAN_W:1];
		s = {1'b0, n} + {1'b0, w};
		plane = n + w - nw;
		p = '0;
		case (mode)
			PM_PIXEL: p = cur;
			PM_W: p = leftcol ? '0 : w;
			PM_N: p = top ? '0 : n;
			PM_NW: p = nw;
			PM_PLANE: p = plane;
			PM_N_HALF: p = n + h;
			PM_W_HALF: begin
				d = {1'b0, n} - {1'b0, nw};
				t = d + {{CHAN_W{1'b0}}, d[CHAN_W]};
				p = w + t[CHAN_W:1];
			end
			PM_AVG: p = s[CHAN_W:1];
			PM_MED: begin
				if (nw >= w && nw >= n) begin
					p = (w < n) ? w : n;
				end else if (nw <= w && nw <= n) begin
					p = (w > n) ? w : n;
				end else begin
					p = plane;
				end
			end
			default: p = '0;
		endcase
		if (mode > PM_N && (top || leftcol)) begin
			p = '0;
		end
		return p;
	endfunction
endpackage
`default_nettype wire

FILE: rtl/lppr_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface lppr_in_if import lppr_pkg::*; ();
	logic valid;
	logic ready;
	logic [CHAN_W-1:0] blue_in;
	logic [CHAN_W-1:0] green_in;
	logic [CHAN_W-1:0] red_in;

	modport source (output valid, output blue_in, output green_in, output red_in,
		input ready);
	modport sink (input valid, input blue_in, input green_in, input red_in,
		output ready);
endinterface
`default_nettype wire

FILE: rtl/lppr_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface lppr_out_if import lppr_pkg::*; ();
	logic valid;
	logic ready;
	logic [CHAN_W-1:0] blue_residual;
	logic [CHAN_W-1:0] green_residual;
	logic [CHAN_W-1:0] red_residual;

	modport source (output valid, output blue_residual, output green_residual,
		output red_residual, input ready);
	modport sink (input valid, input blue_residual, input green_residual,
		input red_residual, output ready);
endinterface
`default_nettype wire

FILE: rtl/lossless_pixel_predictor_residual.sv
// an accepted request is held in the stage 1 registers; its residual is registered at the output when stage 1 moves
// throughput: one pixel per cycle while the output is not stalled, set by one line store read and one write each cycle
// the line store read for column c overlaps the write of the pixel before it
// reset: counters, neighbor pixels and valid flags cleared, mode 8, width and height 1024
// reset: the line store is not cleared and holds no valid state
`timescale 1ns / 1ps
`default_nettype none
`include "lossless_pixel_predictor_residual_macros.svh"
module lossless_pixel_predictor_residual import lppr_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_W-1:0] cfg_data,
	lppr_in_if.sink pix,
	lppr_out_if.source res
);
	logic [MODE_W-1:0] mode_q;
	logic [WIDTH_W-1:0] width_q;
	logic [HEIGHT_W-1:0] height_q;

	logic [ADDR_W-1:0] col_q;
	logic [HEIGHT_W-1:0] row_q;

	logic [PIX_W-1:0] mem [MAX_WIDTH];

	logic valid_s1;
	logic fwd_s1;
	logic top_s1;
	logic leftcol_s1;
	logic [ADDR_W-1:0] col_s1;
	logic [PIX_W-1:0] cur_s1;
	logic [PIX_W-1:0] rd_data_s1;

	logic [PIX_W-1:0] left_q;
	logic [PIX_W-1:0] upleft_q;

	logic out_valid_q;
	logic [PIX_W-1:0] out_res_q;

	logic pix_fire;
	logic s1_move;
	logic s1_wr;
	logic [WEFF_W-1:0] w_eff;
	logic [HEIGHT_W-1:0] h_eff;
	logic wrap_col;
	logic [ADDR_W-1:0] col_adj;
	logic [HEIGHT_W:0] row_inc;
	logic [HEIGHT_W-1:0] row_adj;
	logic [WEFF_W-1:0] col_inc;
	logic end_row;
	logic [HEIGHT_W:0] row_inc2;
	logic [ADDR_W-1:0] col_nxt;
	logic [HEIGHT_W-1:0] row_nxt;
	logic [PIX_W-1:0] north;
	logic [PIX_W-1:0] resid;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RST;
			width_q <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_MODE: mode_q <= cfg_data[MODE_W-1:0];
				CFG_WIDTH: width_q <= cfg_data[WIDTH_W-1:0];
				CFG_HEIGHT: height_q <= cfg_data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	assign s1_move = !out_valid_q || res.ready;
	assign s1_wr = valid_s1 && s1_move;
	assign pix.ready = !valid_s1 || s1_move;
	assign pix_fire = pix.valid && pix.ready;

	// column and row position of the incoming request
	always_comb begin
		if (width_q == '0) begin
			w_eff = WEFF_W'(1);
		end else if (WEFF_W'(width_q) > WEFF_W'(MAX_WIDTH)) begin
			w_eff = WEFF_W'(MAX_WIDTH);
		end else begin
			w_eff = WEFF_W'(width_q);
		end
		h_eff = (height_q == '0) ? HEIGHT_W'(1) : height_q;
		wrap_col = WEFF_W'(col_q) >= w_eff;
		col_adj = wrap_col ? '0 : col_q;
		row_inc = {1'b0, row_q} + (HEIGHT_W+1)'(wrap_col);
		row_adj = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[HEIGHT_W-1:0];
		col_inc = WEFF_W'(col_adj) + WEFF_W'(1);
		end_row = col_inc >= w_eff;
		row_inc2 = {1'b0, row_adj} + (HEIGHT_W+1)'(1);
		col_nxt = end_row ? '0 : col_inc[ADDR_W-1:0];
		if (!end_row) begin
			row_nxt = row_adj;
		end else if (row_inc2 >= {1'b0, h_eff}) begin
			row_nxt = '0;
		end else begin
			row_nxt = row_inc2[HEIGHT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_fire) begin
			col_q <= col_nxt;
			row_q <= row_nxt;
		end
	end

	// line store
	always_ff @(posedge clk) begin
		if (s1_wr) begin
			mem[col_s1] <= cur_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_fire) begin
			rd_data_s1 <= mem[col_adj];
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			if (pix.ready) begin
				valid_s1 <= pix_fire;
			end
			if (pix_fire) begin
				fwd_s1 <= s1_wr && (col_s1 == col_adj);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_fire) begin
			col_s1 <= col_adj;
			top_s1 <= row_adj == '0;
			leftcol_s1 <= col_adj == '0;
			cur_s1 <= {pix.red_in, pix.green_in, pix.blue_in};
		end
	end

	// same entry written by the previous pixel: its value is now the left pixel
	assign north = fwd_s1 ? left_q : rd_data_s1;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			resid[k*CHAN_W +: CHAN_W] = cur_s1[k*CHAN_W +: CHAN_W]
				- predict(mode_q, cur_s1[k*CHAN_W +: CHAN_W], north[k*CHAN_W +: CHAN_W],
					left_q[k*CHAN_W +: CHAN_W], upleft_q[k*CHAN_W +: CHAN_W],
					top_s1, leftcol_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			upleft_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_wr) begin
				left_q <= cur_s1;
				upleft_q <= north;
			end
			if (s1_move) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_wr) begin
			out_res_q <= resid;
		end
	end

	assign res.valid = out_valid_q;
	assign res.blue_residual = out_res_q[CHAN_W-1:0];
	assign res.green_residual = out_res_q[2*CHAN_W-1:CHAN_W];
	assign res.red_residual = out_res_q[3*CHAN_W-1:2*CHAN_W];

	`LPPR_ASSERT_SAME(a_ready_when_out_empty, !out_valid_q, pix.ready)
	`LPPR_ASSERT_NEXT(a_request_enters_s1, pix_fire, valid_s1)
	`LPPR_ASSERT_NEXT(a_s1_holds_on_stall, valid_s1 && !s1_move, valid_s1 && $stable(col_s1))
	`LPPR_ASSERT_NEXT(a_out_follows_s1, s1_wr, out_valid_q)
endmodule
`default_nettype wire

FILE: bench/pixel_residual_checker.sv
`timescale 1ns / 1ps
module pixel_residual_checker import lppr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data,
	lppr_in_if pix,
	lppr_out_if res,
	output int fail_count,
	output int pending,
	output int store_fill,
	output int results_checked
);
	typedef struct packed {
		chan_t blue;
		chan_t green;
		chan_t red;
	} residual_t;

	logic [MODE_W-1:0] mode;
	logic [WIDTH_W-1:0] width;
	logic [HEIGHT_W-1:0] height;
	logic [PIX_W-1:0] line_store [MAX_WIDTH];
	logic written [MAX_WIDTH];
	logic [PIX_W-1:0] west;
	logic [PIX_W-1:0] north_west;
	int column;
	int row;
	int fill;
	int errors;
	int checked;
	residual_t expected_residuals [$];

	function automatic chan_t predict_channel(input logic [MODE_W-1:0] sel, input chan_t cur,
		input chan_t n, input chan_t w, input chan_t nw, input logic top,
		input logic leftcol);
		int sn;
		int sw;
		int snw;
		int sum;
		sn = n;
		sw = w;
		snw = nw;
		sum = 0;
		if (sel == PM_PIXEL) return cur;
		if (sel == PM_W) return leftcol ? '0 : w;
		if (sel == PM_N) return top ? '0 : n;
		if (sel > PM_MED || top || leftcol) return '0;
		case (sel)
			PM_NW: sum = snw;
			PM_PLANE: sum = sn + sw - snw;
			PM_N_HALF: sum = sn + (sw - snw) / 2;
			PM_W_HALF: sum = sw + (sn - snw) / 2;
			PM_AVG: sum = (sn + sw) / 2;
			default: begin
				if (nw >= w && nw >= n) begin
					sum = (w < n) ? sw : sn;
				end else if (nw <= w && nw <= n) begin
					sum = (w > n) ? sw : sn;
				end else begin
					sum = sn + sw - snw;
				end
			end
		endcase
		return sum[CHAN_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		int span;
		int depth;
		logic [PIX_W-1:0] cur;
		logic [PIX_W-1:0] above;
		logic top;
		logic leftcol;
		chan_t diff [3];
		residual_t want;
		residual_t got;
		if (!arst_n) begin
			mode = MODE_RST;
			width = WIDTH_RST;
			height = HEIGHT_RST;
			for (int i = 0; i < MAX_WIDTH; i++) begin
				written[i] = 1'b0;
				line_store[i] = '0;
			end
			west = '0;
			north_west = '0;
			column = 0;
			row = 0;
			fill = 0;
			errors = 0;
			checked = 0;
			expected_residuals.delete();
			fail_count <= 0;
			pending <= 0;
			store_fill <= 0;
			results_checked <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_MODE: mode = cfg_data[MODE_W-1:0];
					CFG_WIDTH: width = cfg_data[WIDTH_W-1:0];
					CFG_HEIGHT: height = cfg_data[HEIGHT_W-1:0];
					default: ;
				endcase
			end
			if (pix.valid && pix.ready) begin
				span = (width == 0) ? 1 : ((width > MAX_WIDTH) ? MAX_WIDTH : width);
				depth = (height == 0) ? 1 : height;
				if (column >= span) begin
					column = 0;
					row++;
				end
				if (row >= depth) row = 0;
				cur = {pix.red_in, pix.green_in, pix.blue_in};
				above = written[column] ? line_store[column] : '0;
				top = (row == 0);
				leftcol = (column == 0);
				for (int k = 0; k < 3; k++) begin
					diff[k] = cur[CHAN_W*k +: CHAN_W] - predict_channel(mode,
						cur[CHAN_W*k +: CHAN_W], above[CHAN_W*k +: CHAN_W],
						west[CHAN_W*k +: CHAN_W], north_west[CHAN_W*k +: CHAN_W],
						top, leftcol);
				end
				want.blue = diff[0];
				want.green = diff[1];
				want.red = diff[2];
				expected_residuals.push_back(want);
				north_west = above;
				west = cur;
				line_store[column] = cur;
				written[column] = 1'b1;
				while (fill < MAX_WIDTH && written[fill]) fill++;
				column++;
				if (column >= span) begin
					column = 0;
					row++;
					if (row >= depth) row = 0;
				end
			end
			if (res.valid && res.ready) begin
				got.blue = res.blue_residual;
				got.green = res.green_residual;
				got.red = res.red_residual;
				if (expected_residuals.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("residual error: unexpected result b=%h g=%h r=%h",
							got.blue, got.green, got.red);
					end
				end else begin
					want = expected_residuals.pop_front();
					if (got.blue !== want.blue || got.green !== want.green ||
						got.red !== want.red) begin
						errors++;
						if (errors <= 10) begin
							$display("residual error at %0d: expected b=%h g=%h r=%h, got b=%h g=%h r=%h",
								checked, want.blue, want.green, want.red,
								got.blue, got.green, got.red);
						end
					end
					checked++;
				end
			end
			fail_count <= errors;
			pending <= expected_residuals.size();
			store_fill <= fill;
			results_checked <= checked;
		end
	end
endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
module testbench import lppr_pkg::*; ();
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 4'd9;
	localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 4'd15;
	localparam int PIXEL_TARGET = 1850;
	localparam int CALM_TAIL = 250;
	localparam int CYCLE_LIMIT = 1000000;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	lppr_in_if pix_if ();
	lppr_out_if res_if ();

	int fail_count;
	int pending;
	int store_fill;
	int results_checked;
	int idle_level;
	int pixels_sent;
	int filler_sent;
	int settings;
	int widest;
	int cycle_count;
	logic [15:0] modes_seen;

	lossless_pixel_predictor_residual DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pix(pix_if),
		.res(res_if)
	);

	pixel_residual_checker residual_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pix(pix_if),
		.res(res_if),
		.fail_count(fail_count),
		.pending(pending),
		.store_fill(store_fill),
		.results_checked(results_checked)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("lossless_pixel_predictor_residual: mismatch");
			$finish;
		end
	end

	initial begin : receiver
		int hold;
		res_if.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (idle_level != 0 && $urandom_range(0, 15) < idle_level) begin
				hold = $urandom_range(1, 19);
				res_if.ready <= 1'b0;
				repeat (hold) @(posedge clk);
				res_if.ready <= 1'b1;
			end
		end
	end

	function automatic chan_t pick_level();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return chan_t'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic push_pixel(input chan_t blue, input chan_t green, input chan_t red);
		if (idle_level != 0 && $urandom_range(0, 15) < idle_level) begin
			pix_if.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.blue_in <= blue;
		pix_if.green_in <= green;
		pix_if.red_in <= red;
		@(posedge clk);
		while (!pix_if.ready) @(posedge clk);
		pixels_sent++;
	endtask

	task automatic push_random();
		push_pixel(pick_level(), pick_level(), pick_level());
	endtask

	task automatic wait_idle();
		pix_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_mode(input logic [MODE_W-1:0] sel);
		logic [CFG_W-1:0] data;
		data = CFG_W'($urandom);
		data[MODE_W-1:0] = sel;
		wait_idle();
		write_reg(CFG_MODE, data);
		modes_seen[sel] = 1'b1;
		settings++;
	endtask

	// widths past the written part of the line store are reached through
	// single-row images, so no unwritten entry is ever used as a north neighbour
	task automatic set_geometry(input logic [WIDTH_W-1:0] width,
		input logic [HEIGHT_W-1:0] height);
		logic [CFG_W-1:0] data;
		int span;
		span = (width == 0) ? 1 : ((width > MAX_WIDTH) ? MAX_WIDTH : width);
		data = CFG_W'($urandom);
		data[WIDTH_W-1:0] = width;
		wait_idle();
		if (span > store_fill) begin
			write_reg(CFG_HEIGHT, CFG_W'(1));
			write_reg(CFG_WIDTH, data);
			while (store_fill < span) begin
				push_random();
				filler_sent++;
			end
			wait_idle();
		end else begin
			write_reg(CFG_WIDTH, data);
		end
		write_reg(CFG_HEIGHT, height);
		if (span > widest) widest = span;
		settings++;
	endtask

	initial begin : stimulus
		logic [MODE_W-1:0] sel;
		logic [WIDTH_W-1:0] width;
		logic [HEIGHT_W-1:0] height;
		int phase;
		int count;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= CFG_MODE;
		cfg_data <= '0;
		pix_if.valid <= 1'b0;
		pix_if.blue_in <= '0;
		pix_if.green_in <= '0;
		pix_if.red_in <= '0;
		idle_level = 0;
		pixels_sent = 0;
		filler_sent = 0;
		settings = 1;
		widest = MAX_WIDTH;
		modes_seen = '0;
		modes_seen[MODE_RST] = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, extreme pixels
		push_pixel(8'h00, 8'h00, 8'h00);
		push_pixel(8'hFF, 8'hFF, 8'hFF);
		push_pixel(8'h00, 8'hFF, 8'h00);
		push_pixel(8'hFF, 8'h00, 8'hFF);
		push_pixel(8'h01, 8'h80, 8'hFE);
		push_pixel(8'h80, 8'h7F, 8'h01);
		wait_idle();
		write_reg(CFG_UNUSED, CFG_W'($urandom));

		// shrinking the width pushes the counters past the row end
		set_geometry(WIDTH_W'(2), HEIGHT_W'(3));
		for (int m = 0; m <= 10; m++) begin
			sel = (m == 9) ? MODE_UNUSED_LO : (m == 10) ? MODE_UNUSED_HI : MODE_W'(m);
			set_mode(sel);
			push_random();
			if (m < 9) push_random();
		end
		set_mode(PM_MED);
		set_geometry('0, '0);
		push_random();
		push_random();

		phase = 0;
		while (pixels_sent < PIXEL_TARGET) begin
			phase++;
			idle_level = (pixels_sent > PIXEL_TARGET - CALM_TAIL) ? 0 :
				$urandom_range(0, 4);
			case ($urandom_range(0, 9))
				0: width = WIDTH_W'($urandom_range(17, 96));
				1: width = WIDTH_W'($urandom_range(0, 1));
				default: width = WIDTH_W'($urandom_range(1, 16));
			endcase
			if (phase == 3) width = '1;
			if (phase == 7) width = WIDTH_W'(MAX_WIDTH);
			if (phase == 11) width = WIDTH_W'($urandom_range(MAX_WIDTH + 1, 2047));
			case ($urandom_range(0, 9))
				0: height = '0;
				1: height = '1;
				2: height = HEIGHT_W'($urandom_range(1, 65535));
				default: height = HEIGHT_W'($urandom_range(1, 6));
			endcase
			set_geometry(width, height);
			if ($urandom_range(0, 9) == 0) begin
				sel = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
			end else begin
				sel = MODE_W'($urandom_range(PM_PIXEL, PM_MED));
			end
			set_mode(sel);
			count = $urandom_range(20, 120);
			for (int i = 0; i < count; i++) begin
				if (pixels_sent > PIXEL_TARGET - CALM_TAIL) idle_level = 0;
				push_random();
				if ($urandom_range(0, 63) == 0) wait_idle();
			end
		end

		idle_level = 0;
		wait_idle();
		repeat (8) @(posedge clk);
		$display("covered %0d pixels (%0d filling the line store) over %0d settings",
			pixels_sent, filler_sent, settings);
		$display("%0d residuals compared, predictor modes written %b, widest row %0d pixels",
			results_checked, modes_seen, widest);
		if (fail_count == 0) begin
			$display("lossless_pixel_predictor_residual: match");
		end else begin
			$display("lossless_pixel_predictor_residual: mismatch");
		end
		$finish;
	end
endmodule

FILE: files.f
+incdir+rtl
rtl/lppr_pkg.sv
rtl/lppr_in_if.sv
rtl/lppr_out_if.sv
rtl/lossless_pixel_predictor_residual.sv
bench/pixel_residual_checker.sv
bench/testbench.sv
